/* hdl/rnmtf_pkg.sv */
`default_nettype none
package rnmtf_pkg;

    // Default sizes
    localparam int ENTRIES_DEF    = 8;
    localparam int NAME_CHARS_DEF = 8;

    // Command codes
    localparam logic [1:0] CMD_USE    = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] name_bytes;
        logic [2:0]  entry_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [2:0]  hit_position;
        logic        dropped;
        logic [3:0]  entry_count;
        logic [63:0] entry_name;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FRONT,
        S_APPEND,
        S_READ_RD,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_SHIFT,
        RD_INDEX
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_SHIFT,
        WR_FRONT,
        WR_APPEND
    } t_wr_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    scan_inc;
        logic    ptr_dec;
        logic    hit;
        logic    miss;
        logic    capture;
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] in_cmd;
        logic       in_empty;
        logic       full;
        logic       in_idx_bad;
        logic       scan_end;
        logic       match;
        logic       ptr_zero;
    } t_sts;

    // Fold ASCII upper case letters to lower case, byte by byte
    function automatic logic [63:0] fold_case(input logic [63:0] v);
        logic [63:0] r;
        logic [7:0]  b;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            b = v[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5A) begin
                b = b + 8'h20;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/rnmtf_ctrl.sv */
`default_nettype none
module rnmtf_ctrl
    import rnmtf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl,
    output logic      o_busy,
    output logic      o_strobe
);

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence each command
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.rd_sel = RD_SCAN;
        o_ctl.wr_sel = WR_SHIFT;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    case (i_sts.in_cmd)
                        CMD_USE:    n_state = i_sts.in_empty ? S_DONE : S_SCAN_RD;
                        CMD_APPEND: n_state = (i_sts.in_empty || i_sts.full) ? S_DONE
                                                                             : S_APPEND;
                        CMD_READ:   n_state = i_sts.in_idx_bad ? S_DONE : S_READ_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    o_ctl.miss = 1'b1;
                    n_state    = S_SHIFT_RD;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_SCAN;
                    n_state      = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    o_ctl.hit = 1'b1;
                    n_state   = S_SHIFT_RD;
                end else begin
                    o_ctl.scan_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.ptr_zero) begin
                    n_state = S_FRONT;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_SHIFT;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_sel  = WR_SHIFT;
                o_ctl.ptr_dec = 1'b1;
                n_state       = S_SHIFT_RD;
            end
            S_FRONT: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = WR_FRONT;
                n_state      = S_DONE;
            end
            S_APPEND: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = WR_APPEND;
                n_state      = S_DONE;
            end
            S_READ_RD: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = RD_INDEX;
                n_state      = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                o_ctl.capture = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

endmodule
`default_nettype wire

/* hdl/rnmtf_dp.sv */
`default_nettype none
module rnmtf_dp
    import rnmtf_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int NAME_CHARS = NAME_CHARS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_item,
    input  wire t_ctl i_ctl,
    output t_sts      o_sts,
    output t_out      o_result
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0]   FULL_COUNT = CW'(ENTRIES);
    localparam logic [CW+2:0]   ENT_EXT    = (CW + 3)'(ENTRIES);

    logic [63:0]   r_mem [ENTRIES];
    logic [63:0]   r_rdata;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic [63:0]   r_name;
    logic [63:0]   r_keep;
    logic [2:0]    r_idx;
    logic [1:0]    r_status;
    logic          r_hit;
    logic [2:0]    r_hpos;
    logic          r_dropped;
    logic [63:0]   r_rd_name;

    logic [63:0]   in_name;
    logic          in_empty;
    logic          full;
    logic          in_idx_bad;
    logic [1:0]    load_status;
    logic [CW+2:0] idx_ext;
    logic [CW+2:0] cnt_ext;
    logic [CW+2:0] ptr_ext;
    logic [AW+2:0] idx_addr_ext;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic [CW-1:0] miss_count;

    // Cut the name at its first zero byte and at the character limit
    always_comb begin
        logic keep_on;
        keep_on = 1'b1;
        in_name = '0;
        for (int i = 0; i < 8; i++) begin
            if (i >= NAME_CHARS || i_item.name_bytes[8*i +: 8] == 8'h00) begin
                keep_on = 1'b0;
            end
            if (keep_on) begin
                in_name[8*i +: 8] = i_item.name_bytes[8*i +: 8];
            end
        end
    end

    assign in_empty   = (in_name == 64'd0);
    assign full       = (r_count == FULL_COUNT);
    assign idx_ext    = {{CW{1'b0}}, i_item.entry_index};
    assign cnt_ext    = {3'b000, r_count};
    assign ptr_ext    = {3'b000, r_ptr};
    assign in_idx_bad = (idx_ext >= cnt_ext) || (idx_ext >= ENT_EXT);
    assign miss_count = full ? r_count : r_count + CW'(1);

    // Pick the status a command reports when it is taken
    always_comb begin
        case (i_item.cmd)
            CMD_USE:    load_status = in_empty ? ST_EMPTY : ST_OK;
            CMD_APPEND: load_status = in_empty ? ST_EMPTY : (full ? ST_FULL : ST_OK);
            CMD_READ:   load_status = in_idx_bad ? ST_RANGE : ST_OK;
            default:    load_status = ST_OK;
        endcase
    end

    // Select the read address
    assign idx_addr_ext = {{AW{1'b0}}, r_idx};
    always_comb begin
        case (i_ctl.rd_sel)
            RD_SCAN:  rd_addr = r_ptr[AW-1:0];
            RD_SHIFT: rd_addr = r_ptr[AW-1:0] - AW'(1);
            RD_INDEX: rd_addr = idx_addr_ext[AW-1:0];
            default:  rd_addr = r_ptr[AW-1:0];
        endcase
    end

    // Select the write address and data
    always_comb begin
        case (i_ctl.wr_sel)
            WR_SHIFT: begin
                wr_addr = r_ptr[AW-1:0];
                wr_data = r_rdata;
            end
            WR_FRONT: begin
                wr_addr = '0;
                wr_data = r_keep;
            end
            WR_APPEND: begin
                wr_addr = r_count[AW-1:0];
                wr_data = r_name;
            end
            default: begin
                wr_addr = r_ptr[AW-1:0];
                wr_data = r_rdata;
            end
        endcase
    end

    // Entry memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Track the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.miss) begin
            r_count <= miss_count;
        end else if (i_ctl.wr_en && i_ctl.wr_sel == WR_APPEND) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Latch the command, walk the pointer and collect result fields
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_name    <= in_name;
            r_idx     <= i_item.entry_index;
            r_ptr     <= '0;
            r_status  <= load_status;
            r_hit     <= 1'b0;
            r_hpos    <= 3'd0;
            r_dropped <= 1'b0;
            r_rd_name <= 64'd0;
        end else begin
            if (i_ctl.scan_inc) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (i_ctl.ptr_dec) begin
                r_ptr <= r_ptr - CW'(1);
            end
            if (i_ctl.hit) begin
                r_hit  <= 1'b1;
                r_hpos <= ptr_ext[2:0];
                r_keep <= r_rdata;
            end
            if (i_ctl.miss) begin
                r_dropped <= full;
                r_ptr     <= miss_count - CW'(1);
                r_keep    <= r_name;
            end
            if (i_ctl.capture) begin
                r_rd_name <= r_rdata;
            end
        end
    end

    assign o_sts.in_cmd     = i_item.cmd;
    assign o_sts.in_empty   = in_empty;
    assign o_sts.full       = full;
    assign o_sts.in_idx_bad = in_idx_bad;
    assign o_sts.scan_end   = (r_ptr == r_count);
    assign o_sts.match      = (fold_case(r_rdata) == fold_case(r_name));
    assign o_sts.ptr_zero   = (r_ptr == '0);

    assign o_result.status       = r_status;
    assign o_result.hit          = r_hit;
    assign o_result.hit_position = r_hpos;
    assign o_result.dropped      = r_dropped;
    assign o_result.entry_count  = cnt_ext[3:0];
    assign o_result.entry_name   = r_rd_name;

endmodule
`default_nettype wire

/* hdl/recent_name_move_to_front_list_core.sv */
`default_nettype none
// Channel   Handshake                  Payload
// command   i_start, o_busy            i_item   (t_in)
// result    o_strobe (one cycle)       o_result (t_out)
//
// A command is taken at a clock edge with i_start high and o_busy low.
// Use compares entries from the front, reading and comparing each; on a hit it shifts the
// entries ahead of the match back one place, on a miss all of them, then writes the front.
// Append writes one entry, read fetches one; an ignored command leaves the memory alone.
// Synchronous active-low reset empties the list; no clearing pass is needed.
// The result beat is shown on o_strobe for one cycle; the receiver cannot stall it.
module recent_name_move_to_front_list_core
    import rnmtf_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int NAME_CHARS = NAME_CHARS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_item,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out      o_result
);

    t_ctl ctl;
    t_sts sts;

    rnmtf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_sts    (sts),
        .o_ctl    (ctl),
        .o_busy   (o_busy),
        .o_strobe (o_strobe)
    );

    rnmtf_dp #(
        .ENTRIES    (ENTRIES),
        .NAME_CHARS (NAME_CHARS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
